// File: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent assertion, sampled on the rising clock edge and muted in reset.
`define FDL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("fdl assertion failed");

// Same-cycle implication built on the plain form.
`define FDL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	`FDL_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication built on the plain form.
`define FDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	`FDL_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// File: hw/rtl/fdl_pkg.sv
`default_nettype none

package fdl_pkg;

	localparam int CH_W       = 4;
	localparam int LEVEL_W    = 11;
	localparam int TIME_W     = 32;
	localparam int DEBOUNCE_W = 16;
	localparam int EXEMPT_W   = 4;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 3;
	localparam int REG_IDX_W  = 1;

	localparam int CHANNELS_DEF = 11;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;
	localparam logic [EXEMPT_W-1:0]   EXEMPT_RESET   = 4'd10;

	localparam logic OP_EDGE  = 1'b0;
	localparam logic OP_REARM = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_EXEMPT   = 1'd1;

	typedef struct packed {
		logic                  operation;
		logic [CH_W-1:0]       channel;
		logic [LEVEL_W-1:0]    pressed_levels;
		logic [TIME_W-1:0]     now;
	} req_t;

	typedef struct packed {
		logic [DEBOUNCE_W-1:0] debounce_ms;
		logic [EXEMPT_W-1:0]   exempt_channel;
	} cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/fdl_req_if.sv
`default_nettype none

interface fdl_req_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [fdl_pkg::CH_W-1:0]      channel;
	logic [fdl_pkg::LEVEL_W-1:0]   pressed_levels;
	logic [fdl_pkg::TIME_W-1:0]    now;

	modport source (
		output valid, operation, channel, pressed_levels, now,
		input  ready
	);

	modport sink (
		input  valid, operation, channel, pressed_levels, now,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/fdl_evt_if.sv
`default_nettype none

interface fdl_evt_if;
	logic                         valid;
	logic                         ready;
	logic                         is_down;
	logic [fdl_pkg::CH_W-1:0]     source_channel;
	logic [fdl_pkg::TIME_W-1:0]   event_time;

	modport source (
		output valid, is_down, source_channel, event_time,
		input  ready
	);

	modport sink (
		input  valid, is_down, source_channel, event_time,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/fdl_cfg.sv
`default_nettype none

module fdl_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fdl_pkg::ADDR_W-1:0]   paddr,
	input  logic [fdl_pkg::DATA_W-1:0]   pwdata,
	output logic [fdl_pkg::DATA_W-1:0]   prdata,
	output fdl_pkg::cfg_t                cfg
);
	import fdl_pkg::*;

	logic [DEBOUNCE_W-1:0] debounce_q;
	logic [EXEMPT_W-1:0]   exempt_q;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			exempt_q   <= EXEMPT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DEBOUNCE: begin
					debounce_q <= pwdata[DEBOUNCE_W-1:0];
				end
				REG_EXEMPT: begin
					exempt_q <= pwdata[EXEMPT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DEBOUNCE: prdata = DATA_W'(debounce_q);
			REG_EXEMPT:   prdata = DATA_W'(exempt_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.debounce_ms    = debounce_q;
	assign cfg.exempt_channel = exempt_q;

endmodule

`default_nettype wire

// File: hw/rtl/fdl_track.sv
`default_nettype none

module fdl_track #(
	parameter int CHANNELS = fdl_pkg::CHANNELS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           commit,
	input  fdl_pkg::req_t  item,
	input  fdl_pkg::cfg_t  cfg,
	output logic           emit,
	output logic           is_down
);
	import fdl_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [TIME_W-1:0]         last_q [CHANNELS];
	logic [CHANNELS-1:0]       latch_q;
	logic [CHANNELS-1:0]       clr_mask;
	logic [CH_W+IDX_W-1:0]     idx_ext;
	logic [IDX_W-1:0]          idx;
	logic                      in_range;
	logic                      level;
	logic                      exempt;
	logic [TIME_W-1:0]         elapsed;
	logic                      time_ok;
	logic                      latched;

	localparam logic [CH_W-1:0] LEVEL_LIMIT = CH_W'(LEVEL_W);

	assign idx_ext  = {{IDX_W{1'b0}}, item.channel};
	assign idx      = idx_ext[IDX_W-1:0];
	assign in_range = 32'(item.channel) < 32'(CHANNELS);
	assign level    = (item.channel < LEVEL_LIMIT) ? item.pressed_levels[item.channel] : 1'b0;
	assign exempt   = (item.channel == cfg.exempt_channel);
	assign latched  = latch_q[idx];
	assign elapsed  = item.now - last_q[idx];
	assign time_ok  = elapsed >= {{(TIME_W-DEBOUNCE_W){1'b0}}, cfg.debounce_ms};

	assign emit = (item.operation == OP_EDGE) && in_range && time_ok
		&& (exempt || (level ? !latched : latched));
	assign is_down = level;

	// A rearm releases every latch whose switch is up, except on the exempt channel.
	for (genvar i = 0; i < CHANNELS; i++) begin : g_clr
		logic lvl_i;
		if (i < LEVEL_W) begin : g_lvl
			assign lvl_i = item.pressed_levels[i];
		end else begin : g_nolvl
			assign lvl_i = 1'b0;
		end
		assign clr_mask[i] = (32'(cfg.exempt_channel) != 32'(i)) && !lvl_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				last_q[i] <= '0;
			end
		end else if (commit) begin
			if (item.operation == OP_REARM) begin
				latch_q <= latch_q & ~clr_mask;
			end else if (emit) begin
				latch_q[idx] <= level;
				last_q[idx]  <= item.now;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/footswitch_event_debounce_latch.sv
// Footswitch event qualifier for up to CHANNELS switches. Each transfer on req
// either reports an edge on one channel, together with the current pressed
// levels of all switches and the millisecond tick, or asks for a rearm sweep.
// An edge turns into at most one transfer on evt: a down event when a switch is
// pressed and its channel is not latched, an up event when it is released and
// latched, and nothing when the channel saw an event fewer than debounce_ms
// ticks ago (wrapping 32-bit difference). The exempt channel reports every
// edge that passes the debounce test. A rearm clears the latches of all
// released channels except the exempt one and reports nothing. The block takes
// one req transfer per clock cycle unless evt stalls it; an event passes from
// the first-stage register into the output register that offers it on evt,
// and the next req is taken as its item leaves unless an earlier event waits. The
// per-channel tick and latch state sits in flip-flops that reset clears at
// once, so the block is ready right after reset. Registers on the APB port:
// debounce_ms at byte address 0 and exempt_channel at byte address 4; change
// them only while no work is in flight.
`default_nettype none

module footswitch_event_debounce_latch #(
	parameter int CHANNELS = fdl_pkg::CHANNELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	fdl_req_if.sink                      req,
	fdl_evt_if.source                    evt,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fdl_pkg::ADDR_W-1:0]   paddr,
	input  logic [fdl_pkg::DATA_W-1:0]   pwdata,
	output logic [fdl_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import fdl_pkg::*;

	cfg_t                cfg;
	req_t                item_s1;
	logic                valid_s1;
	logic                emit;
	logic                is_down;
	logic                out_free;
	logic                go_s1;
	logic                evt_valid_q;
	logic                is_down_q;
	logic [CH_W-1:0]     source_channel_q;
	logic [TIME_W-1:0]   event_time_q;

	assign pready = 1'b1;

	fdl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The item in the first stage leaves as soon as the output register can take
	// its event, or at once when it produces no event.
	assign out_free  = !evt_valid_q || evt.ready;
	assign go_s1     = valid_s1 && (out_free || !emit);
	assign req.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.operation      <= req.operation;
			item_s1.channel        <= req.channel;
			item_s1.pressed_levels <= req.pressed_levels;
			item_s1.now            <= req.now;
		end
	end

	// Channel state is read and written in the same cycle, so the next item in
	// the first stage always sees the update left by the one before it.
	fdl_track #(
		.CHANNELS (CHANNELS)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (go_s1),
		.item    (item_s1),
		.cfg     (cfg),
		.emit    (emit),
		.is_down (is_down)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (go_s1 && emit) begin
			evt_valid_q <= 1'b1;
		end else if (evt.ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			is_down_q        <= is_down;
			source_channel_q <= item_s1.channel;
			event_time_q     <= item_s1.now;
		end
	end

	assign evt.valid          = evt_valid_q;
	assign evt.is_down        = is_down_q;
	assign evt.source_channel = source_channel_q;
	assign evt.event_time     = event_time_q;

endmodule

`default_nettype wire

// File: hw/rtl/fdl_chk.sv
`default_nettype none
`include "assert_macros.svh"

module fdl_chk #(
	parameter int CHANNELS = fdl_pkg::CHANNELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         evt_valid,
	input  logic                         evt_ready,
	input  logic                         evt_is_down,
	input  logic [fdl_pkg::CH_W-1:0]     evt_source_channel,
	input  logic [fdl_pkg::TIME_W-1:0]   evt_event_time,
	input  logic [fdl_pkg::DATA_W-1:0]   prdata,
	input  logic                         pready
);
	import fdl_pkg::*;

	// A stalled event keeps its contents until it is taken.
	`FDL_ASSERT_NEXT(a_evt_hold, clk, arst_n, evt_valid && !evt_ready, evt_valid && $stable(evt_is_down) && $stable(evt_source_channel) && $stable(evt_event_time))

	// Events only ever name channels that exist.
	`FDL_ASSERT_IMPL(a_evt_chan, clk, arst_n, evt_valid, 32'(evt_source_channel) < 32'(CHANNELS))

	// Register reads never show bits above the widest register.
	`FDL_ASSERT(a_prdata_upper, clk, arst_n, prdata[DATA_W-1:DEBOUNCE_W] == '0)

	// The APB port never inserts wait states.
	`FDL_ASSERT(a_pready, clk, arst_n, pready)

endmodule

bind footswitch_event_debounce_latch fdl_chk #(
	.CHANNELS (CHANNELS)
) u_fdl_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.evt_valid          (evt.valid),
	.evt_ready          (evt.ready),
	.evt_is_down        (evt.is_down),
	.evt_source_channel (evt.source_channel),
	.evt_event_time     (evt.event_time),
	.prdata             (prdata),
	.pready             (pready)
);

`default_nettype wire
